// ===== sv/pfsa_pkg.sv =====
// pfsa_pkg: shared types, codes and sizes of the page frame stack allocator
// used by the interfaces, the controller, the datapath and the top level
// no dependencies
package pfsa_pkg;

    localparam int FRAME_W    = 12;
    localparam int FRAMES     = 4096;
    localparam int RESERVED   = 2048;
    localparam int CNT_W      = 13;
    localparam int ROW_BITS   = 32;
    localparam int BIT_W      = 5;
    localparam int ROW_W      = FRAME_W - BIT_W;
    localparam int ROWS       = FRAMES / ROW_BITS;
    localparam int INIT_COUNT = (RESERVED < FRAMES) ? (FRAMES - RESERVED) : 0;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;

    typedef logic [FRAME_W-1:0]  frame_t;
    typedef logic [CNT_W-1:0]    count_t;
    typedef logic [ROW_W-1:0]    row_idx_t;
    typedef logic [ROW_BITS-1:0] row_t;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_ENABLE  = 2'd2,
        OP_DISABLE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 3'd0,
        STS_EMPTY   = 3'd1,
        STS_ABSENT  = 3'd2,
        STS_FULL    = 3'd3,
        STS_ALREADY = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_POP,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic pop_read;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic in_alloc;
        logic clear_last;
        logic out_busy;
    } sts_t;

    // present bits of one row right after reset
    function automatic row_t init_row(input row_idx_t row);
        row_t r;
        r = '0;
        for (int b = 0; b < ROW_BITS; b++)
        begin
            r[b] = ((int'(row) * ROW_BITS + b) < RESERVED);
        end
        return r;
    endfunction

endpackage

// ===== sv/pfsa_req_if.sv =====
// pfsa_req_if: request channel of the allocator, valid/ready with operation and frame
// depends on pfsa_pkg
interface pfsa_req_if
    import pfsa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [FRAME_W-1:0]  frame_number;

    modport source (output valid, output operation, output frame_number, input ready);
    modport sink   (input valid, input operation, input frame_number, output ready);
endinterface

// ===== sv/pfsa_rsp_if.sv =====
// pfsa_rsp_if: result channel of the allocator, valid/ready with frame and status
// depends on pfsa_pkg
interface pfsa_rsp_if
    import pfsa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FRAME_W-1:0]  given_frame;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output given_frame, output status, input ready);
    modport sink   (input valid, input given_frame, input status, output ready);
endinterface

// ===== sv/page_frame_stack_allocator_unit.sv =====
// page_frame_stack_allocator_unit: lifo allocator of physical page frames
// an allocate steps through the states idle, pop and update, other operations
// through idle and update, set by the read then write of the stack and present
// bit memories; update waits while the result register is held, and no request
// is taken until the last one is through; reset: present bits are rebuilt row by row
// in a clearing pass over the 128 rows, req.ready low; the stack needs no pass
module page_frame_stack_allocator_unit
    import pfsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pfsa_req_if.sink   req,
    pfsa_rsp_if.source rsp
);

    cmd_t cmd;
    sts_t sts;

    pfsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfsa_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_operation    (req.operation),
        .in_frame_number (req.frame_number),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_given_frame (rsp.given_frame),
        .out_status      (rsp.status)
    );

    // one item in flight: no transfer right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while an operation is in flight");

    // a result is loaded only into a free result register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(rsp.valid && !rsp.ready))
        else $error("result register overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("result not shown after commit");

    // a refused allocate hands out no frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == STS_EMPTY)) |-> (rsp.given_frame == '0))
        else $error("frame given on empty stack");

endmodule

// ===== sv/pfsa_ctrl.sv =====
// pfsa_ctrl: sequencer of the allocator, clearing pass then one operation at a time
// depends on pfsa_pkg; drives the datapath through cmd_t and reads sts_t
module pfsa_ctrl
    import pfsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.in_alloc ? ST_POP : ST_UPDATE;
                end
            end
            ST_POP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // wait until the result register can take the result
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_POP:
            begin
                cmd.pop_read = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.commit = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/pfsa_dp.sv =====
// pfsa_dp: datapath of the allocator: free stack memory, present bit memory,
// stack count, low-water mark and result register; depends on pfsa_pkg
module pfsa_dp
    import pfsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [OP_W-1:0]     in_operation,
    input  logic [FRAME_W-1:0]  in_frame_number,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [FRAME_W-1:0]  out_given_frame,
    output logic [STATUS_W-1:0] out_status
);

    // stack entries below the lowest count ever reached are never written; a pop there computes the frame
    frame_t   stack_mem [FRAMES];
    row_t     prs_mem   [ROWS];

    frame_t   stk_rd_reg;
    row_t     prs_rd_reg;
    count_t   count_reg;
    count_t   count_next;
    count_t   mark_reg;
    count_t   mark_next;
    row_idx_t clr_reg;
    logic [OP_W-1:0] op_reg;
    frame_t   frame_reg;
    frame_t   pop_frame_reg;
    logic     out_valid_reg;
    frame_t   given_reg;
    status_t  status_reg;

    count_t   top_idx;
    frame_t   popped;
    frame_t   target;
    logic     tgt_valid;
    logic     tgt_bit;
    row_t     row_mod;
    logic     row_we;
    logic     push;
    frame_t   given;
    status_t  status;
    row_idx_t prs_ra;
    row_idx_t prs_wa;
    row_t     prs_wd;
    logic     prs_we;

    assign top_idx = count_reg - count_t'(1);
    assign popped  = (top_idx < mark_reg)
                   ? (frame_t'(FRAMES - 1) - top_idx[FRAME_W-1:0]) : stk_rd_reg;

    assign sts.in_alloc   = (in_operation == OP_ALLOC);
    assign sts.clear_last = (clr_reg == row_idx_t'(ROWS - 1));
    assign sts.out_busy   = out_valid_reg && !out_ready;

    // stack memory: read the top at accept, write on a push
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            stk_rd_reg <= stack_mem[top_idx[FRAME_W-1:0]];
        end
        if (cmd.commit && push)
        begin
            stack_mem[count_reg[FRAME_W-1:0]] <= frame_reg;
        end
    end

    // present bit memory, one row per access
    assign prs_ra = cmd.accept ? in_frame_number[FRAME_W-1:BIT_W] : popped[FRAME_W-1:BIT_W];
    assign prs_we = cmd.clear || (cmd.commit && row_we);
    assign prs_wa = cmd.clear ? clr_reg : target[FRAME_W-1:BIT_W];
    assign prs_wd = cmd.clear ? init_row(clr_reg) : row_mod;

    always_ff @(posedge clk)
    begin
        if (cmd.accept || cmd.pop_read)
        begin
            prs_rd_reg <= prs_mem[prs_ra];
        end
        if (prs_we)
        begin
            prs_mem[prs_wa] <= prs_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= in_operation;
            frame_reg <= in_frame_number;
        end
        if (cmd.pop_read)
        begin
            pop_frame_reg <= popped;
        end
        if (cmd.commit)
        begin
            given_reg  <= given;
            status_reg <= status;
        end
    end

    assign target    = (op_reg == OP_ALLOC) ? pop_frame_reg : frame_reg;
    assign tgt_valid = (count_t'(target) < count_t'(FRAMES));
    assign tgt_bit   = prs_rd_reg[target[BIT_W-1:0]];

    always_comb
    begin
        row_mod    = prs_rd_reg;
        row_we     = 1'b0;
        push       = 1'b0;
        given      = '0;
        status     = STS_OK;
        count_next = count_reg;
        mark_next  = mark_reg;
        case (op_reg)
            OP_ALLOC:
            begin
                if (count_reg == '0)
                begin
                    status = STS_EMPTY;
                end
                else
                begin
                    count_next = top_idx;
                    if (top_idx < mark_reg)
                    begin
                        mark_next = top_idx;
                    end
                    given = pop_frame_reg;
                    if (tgt_valid)
                    begin
                        if (tgt_bit)
                        begin
                            status = STS_ALREADY;
                        end
                        else
                        begin
                            row_mod[target[BIT_W-1:0]] = 1'b1;
                            row_we = 1'b1;
                        end
                    end
                end
            end
            OP_FREE:
            begin
                if (!tgt_valid || !tgt_bit)
                begin
                    status = STS_ABSENT;
                end
                else if (count_reg >= count_t'(FRAMES))
                begin
                    status = STS_FULL;
                end
                else
                begin
                    row_mod[target[BIT_W-1:0]] = 1'b0;
                    row_we     = 1'b1;
                    push       = 1'b1;
                    count_next = count_reg + count_t'(1);
                end
            end
            OP_ENABLE:
            begin
                row_mod[target[BIT_W-1:0]] = 1'b1;
                row_we = tgt_valid;
            end
            OP_DISABLE:
            begin
                row_mod[target[BIT_W-1:0]] = 1'b0;
                row_we = tgt_valid;
            end
            default:
            begin
                row_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= count_t'(INIT_COUNT);
            mark_reg      <= count_t'(INIT_COUNT);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                count_reg <= count_next;
                mark_reg  <= mark_next;
            end
            if (cmd.clear && !sts.clear_last)
            begin
                clr_reg <= clr_reg + row_idx_t'(1);
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_given_frame = given_reg;
    assign out_status      = status_reg;

endmodule
